// ----- hdl/point_in_quad_set_test_macros.svh -----
// Assertion macros for the point-in-quad set test.
// Included by the top level; relies on clk and rst_n in the including scope.
`ifndef POINT_IN_QUAD_SET_TEST_MACROS_SVH
`define POINT_IN_QUAD_SET_TEST_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PQST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PQST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pqst_pkg.sv -----
// Shared constants and types for the point-in-quad set test.
// No dependencies; imported by the top level.
package pqst_pkg;

  // Table size and vertex width.
  localparam int MAX_OBJECTS = 16;
  localparam int COORD_BITS  = 16;
  localparam int CORNERS     = 4;
  localparam int LAST_CORNER = 3;

  // Fixed field widths of the ports.
  localparam int IN_COORD_W = 16;
  localparam int CELL_W     = 15;
  localparam int SLOT_IN_W  = 4;
  localparam int CORNER_W   = 2;
  localparam int COUNT_W    = 5;

  // Derived widths.
  localparam int SLOT_W  = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CNT_W   = $clog2(MAX_OBJECTS + 1);
  localparam int COORD_W = (COORD_BITS > IN_COORD_W) ? COORD_BITS : IN_COORD_W;
  localparam int DIFF_W  = COORD_W + 2;
  localparam int PROD_W  = 2 * DIFF_W;

  // Request codes.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef coord_t [CORNERS-1:0]         quad_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

endpackage

// ----- hdl/point_in_quad_set_test.sv -----
// Point-in-quad set test: vertex table in memory and a crossing-number pipeline.
// Depends on pqst_pkg and point_in_quad_set_test_macros.svh.
// A query reads the first N quads, N being the clamped object count, and strobes its result
// once the read, difference and product stages have drained; busy drops with the strobe.
// Throughput: one quad read per cycle.
// A vertex write leaves busy low. The receiver cannot stall.
// Reset (synchronous, rst_n low) clears control and the count; the table stays unwritten.
`include "point_in_quad_set_test_macros.svh"

module point_in_quad_set_test
  import pqst_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  // Request channel
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_req_type,
  input  logic [SLOT_IN_W-1:0]         in_object_slot,
  input  logic [CORNER_W-1:0]          in_corner,
  input  logic signed [IN_COORD_W-1:0] in_vert_x,
  input  logic signed [IN_COORD_W-1:0] in_vert_y,
  input  logic [CELL_W-1:0]            in_cell_x,
  input  logic [CELL_W-1:0]            in_cell_y,
  // Result channel
  output logic                         out_valid,
  output logic                         out_inside_res,
  // Configuration channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [COUNT_W-1:0]           cfg_object_count
);

  typedef enum logic {ST_IDLE, ST_RUN} st_t;

  st_t                  state_r, state_nxt;
  logic                 busy_r, busy_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_inside_r, out_inside_nxt;
  logic [CNT_W-1:0]     iss_cnt_r, iss_cnt_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic                 acc_r, acc_nxt;
  logic                 v1_r, v2_r, v3_r;
  logic [COUNT_W-1:0]   cfg_count_r;

  logic                 accept;
  logic                 tbl_we;
  logic [SLOT_W-1:0]    wr_addr;
  logic                 rd_en;
  logic [CNT_W-1:0]     n_clamped;
  logic                 drained;

  // Vertex memories, one row per quad, one lane per corner.
  quad_t                mem_x [MAX_OBJECTS];
  quad_t                mem_y [MAX_OBJECTS];
  quad_t                rd_x_r, rd_y_r;

  // Query point.
  logic [CELL_W-1:0]    px_r, py_r;

  // Edge pipeline registers.
  diff_t                a_r   [CORNERS];
  diff_t                dx_r  [CORNERS];
  diff_t                dpx_r [CORNERS];
  diff_t                dy_r  [CORNERS];
  logic [CORNERS-1:0]   str2_r;
  prod_t                lhs_r [CORNERS];
  prod_t                rhs_r [CORNERS];
  logic [CORNERS-1:0]   dpos_r;
  logic [CORNERS-1:0]   str3_r;

  diff_t                a_w   [CORNERS];
  diff_t                b_w   [CORNERS];
  diff_t                dx_w  [CORNERS];
  diff_t                dpx_w [CORNERS];
  diff_t                dy_w  [CORNERS];
  logic [CORNERS-1:0]   str_w;
  logic [CORNERS-1:0]   edge_left;
  logic                 quad_hit;

  assign accept    = start && !busy_r;
  assign tbl_we    = accept && (in_req_type == REQ_WRITE)
                     && (32'(in_object_slot) < 32'(MAX_OBJECTS));
  assign wr_addr   = SLOT_W'(in_object_slot);
  assign rd_en     = (state_r == ST_RUN) && (iss_cnt_r < n_r);
  assign n_clamped = (32'(cfg_count_r) > 32'(MAX_OBJECTS)) ? CNT_W'(MAX_OBJECTS)
                                                          : CNT_W'(cfg_count_r);
  assign drained   = (iss_cnt_r == n_r) && !v1_r && !v2_r && !v3_r;

  // Configuration register; the user must write it only while idle, the block itself does not enforce this.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cfg_count_r <= cfg_object_count;
    end
  end

  // Vertex memory: lane write on a vertex transfer, registered row read.
  // Writes only happen while idle, so a query never overlaps a write.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      mem_x[wr_addr][in_corner] <= coord_t'(in_vert_x);
      mem_y[wr_addr][in_corner] <= coord_t'(in_vert_y);
    end
    if (rd_en) begin
      rd_x_r <= mem_x[iss_cnt_r[SLOT_W-1:0]];
      rd_y_r <= mem_y[iss_cnt_r[SLOT_W-1:0]];
    end
  end

  // Differences against the query point and along every edge (vertex i to previous vertex j).
  always_comb begin
    for (int i = 0; i < CORNERS; i++) begin
      int j;
      j = (i == 0) ? LAST_CORNER : i - 1;
      a_w[i]   = diff_t'(py_r) - diff_t'($signed(rd_y_r[i]));
      b_w[i]   = diff_t'(py_r) - diff_t'($signed(rd_y_r[j]));
      dx_w[i]  = diff_t'($signed(rd_x_r[j])) - diff_t'($signed(rd_x_r[i]));
      dpx_w[i] = diff_t'(px_r) - diff_t'($signed(rd_x_r[i]));
      dy_w[i]  = diff_t'($signed(rd_y_r[j])) - diff_t'($signed(rd_y_r[i]));
      // Straddle: one end strictly below the row, the other at or above it.
      str_w[i] = (!a_w[i][DIFF_W-1] && (a_w[i] != '0) && (b_w[i][DIFF_W-1] || (b_w[i] == '0)))
              || (!b_w[i][DIFF_W-1] && (b_w[i] != '0) && (a_w[i][DIFF_W-1] || (a_w[i] == '0)));
    end
  end

  // Query capture, difference stage and product stage.
  always_ff @(posedge clk) begin
    if (accept && (in_req_type == REQ_QUERY)) begin
      px_r <= in_cell_x;
      py_r <= in_cell_y;
    end
    for (int i = 0; i < CORNERS; i++) begin
      a_r[i]    <= a_w[i];
      dx_r[i]   <= dx_w[i];
      dpx_r[i]  <= dpx_w[i];
      dy_r[i]   <= dy_w[i];
      lhs_r[i]  <= a_r[i] * dx_r[i];
      rhs_r[i]  <= dpx_r[i] * dy_r[i];
      dpos_r[i] <= !dy_r[i][DIFF_W-1] && (dy_r[i] != '0);
    end
    str2_r <= str_w;
    str3_r <= str2_r;
  end

  // Compare cross-products in the direction of dy and take crossing parity.
  always_comb begin
    quad_hit = 1'b0;
    for (int i = 0; i < CORNERS; i++) begin
      edge_left[i] = dpos_r[i] ? (lhs_r[i] < rhs_r[i]) : (lhs_r[i] > rhs_r[i]);
      quad_hit     = quad_hit ^ (str3_r[i] && edge_left[i]);
    end
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt      = state_r;
    busy_nxt       = busy_r;
    out_valid_nxt  = 1'b0;
    out_inside_nxt = out_inside_r;
    iss_cnt_nxt    = iss_cnt_r;
    n_nxt          = n_r;
    acc_nxt        = acc_r;
    if (v3_r) begin
      acc_nxt = acc_r | quad_hit;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_req_type == REQ_QUERY)) begin
          state_nxt   = ST_RUN;
          busy_nxt    = 1'b1;
          iss_cnt_nxt = '0;
          n_nxt       = n_clamped;
          acc_nxt     = 1'b0;
        end
      end
      ST_RUN: begin
        if (rd_en) begin
          iss_cnt_nxt = iss_cnt_r + CNT_W'(1);
        end
        if (drained) begin
          state_nxt      = ST_IDLE;
          busy_nxt       = 1'b0;
          out_valid_nxt  = 1'b1;
          out_inside_nxt = acc_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  // Sequencer state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      out_inside_r <= 1'b0;
      iss_cnt_r    <= '0;
      n_r          <= '0;
      acc_r        <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      busy_r       <= busy_nxt;
      out_valid_r  <= out_valid_nxt;
      out_inside_r <= out_inside_nxt;
      iss_cnt_r    <= iss_cnt_nxt;
      n_r          <= n_nxt;
      acc_r        <= acc_nxt;
      v1_r         <= rd_en;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
    end
  end

  assign busy           = busy_r;
  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;

  // A query transfer always makes the block busy on the next cycle.
  `PQST_ASSERT_NEXT(a_query_busy, accept && (in_req_type == REQ_QUERY), busy_r, "query did not start")
  // The result strobe lasts exactly one cycle.
  `PQST_ASSERT_NEXT(a_strobe_once, out_valid_r, !out_valid_r, "result strobe held")
  // A result only leaves once the pipeline is empty and every quad was read.
  `PQST_ASSERT_NOW(a_drained_out, out_valid_r, drained, "result before drain")
  // A query starts reading at the first quad.
  `PQST_ASSERT_NOW(a_start_zero, $rose(busy_r), iss_cnt_r == '0, "query began at a nonzero quad")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for point_in_quad_set_test: loads vertex quads, sets the object
// count, and checks each query answer against an in-bench crossing-number predictor.
// Depends on pqst_pkg and the point_in_quad_set_test RTL.
module tb;
  import pqst_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT   = 2000;
  localparam int REPORT_MAX    = 10;
  localparam int TABLE_DEPTH   = MAX_OBJECTS * CORNERS;
  localparam int CELL_MAX      = 32767;
  localparam int VERT_MIN      = -32768;
  localparam int VERT_MAX      = 32767;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 34;

  typedef struct {
    logic                         req_type;
    logic [SLOT_IN_W-1:0]         slot;
    logic [CORNER_W-1:0]          corner;
    logic signed [IN_COORD_W-1:0] vx;
    logic signed [IN_COORD_W-1:0] vy;
    logic [CELL_W-1:0]            cx;
    logic [CELL_W-1:0]            cy;
  } quad_req_t;

  // Clock, reset and block ports.
  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         in_req_type = REQ_WRITE;
  logic [SLOT_IN_W-1:0]         in_object_slot = '0;
  logic [CORNER_W-1:0]          in_corner = '0;
  logic signed [IN_COORD_W-1:0] in_vert_x = '0;
  logic signed [IN_COORD_W-1:0] in_vert_y = '0;
  logic [CELL_W-1:0]            in_cell_x = '0;
  logic [CELL_W-1:0]            in_cell_y = '0;
  logic                         out_valid;
  logic                         out_inside_res;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [COUNT_W-1:0]           cfg_object_count = '0;

  // Predictor state: vertex tables and object count as the block should hold them.
  coord_t      vert_x_mem [TABLE_DEPTH];
  coord_t      vert_y_mem [TABLE_DEPTH];
  int unsigned count_cfg = 0;

  // Vertices as queued by the stimulus, used to aim queries at loaded quads.
  int plan_x [TABLE_DEPTH];
  int plan_y [TABLE_DEPTH];

  bit          inside_expected [$];
  quad_req_t   pending_reqs [$];
  quad_req_t   cur_req;
  int unsigned reqs_queued = 0;
  int unsigned reqs_done = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_wait = 0;
  int unsigned stall_cycles = 0;
  bit          calm = 1'b0;
  bit          inside_want;

  point_in_quad_set_test dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_object_slot   (in_object_slot),
    .in_corner        (in_corner),
    .in_vert_x        (in_vert_x),
    .in_vert_y        (in_vert_y),
    .in_cell_x        (in_cell_x),
    .in_cell_y        (in_cell_y),
    .out_valid        (out_valid),
    .out_inside_res   (out_inside_res),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_object_count (cfg_object_count)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Crossing-number test of one stored quad; the intercept compare uses cross-products
  // whose direction follows the sign of the edge's dy.
  function automatic bit quad_holds(int base, longint px, longint py);
    bit     odd = 1'b0;
    int     j = LAST_CORNER;
    longint xi, yi, xj, yj, dy, lhs, rhs;
    bit     left_of;
    for (int i = 0; i < CORNERS; i++) begin
      xi = vert_x_mem[base + i];
      yi = vert_y_mem[base + i];
      xj = vert_x_mem[base + j];
      yj = vert_y_mem[base + j];
      if ((yi < py && yj >= py) || (yj < py && yi >= py)) begin
        dy = yj - yi;
        lhs = (py - yi) * (xj - xi);
        rhs = (px - xi) * dy;
        left_of = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
        if (left_of) odd = !odd;
      end
      j = i;
    end
    return odd;
  endfunction

  // Update the tables for a vertex write, or queue the answer of a query.
  function automatic void apply_req(quad_req_t r);
    int unsigned n;
    bit          hit = 1'b0;
    if (r.req_type == REQ_WRITE) begin
      if (r.slot < MAX_OBJECTS) begin
        vert_x_mem[r.slot * CORNERS + r.corner] = r.vx;
        vert_y_mem[r.slot * CORNERS + r.corner] = r.vy;
      end
    end else begin
      n = (count_cfg > MAX_OBJECTS) ? MAX_OBJECTS : count_cfg;
      for (int k = 0; k < n; k++) begin
        if (quad_holds(k * CORNERS, longint'(r.cx), longint'(r.cy))) hit = 1'b1;
      end
      inside_expected.insert(inside_expected.size(), hit);
    end
  endfunction

  // Driver: presents queued items with random gaps and holds each one until transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_req(cur_req);
        reqs_done++;
        send_wait = calm ? 0 : $urandom_range(0, 8);
      end
      if (!(start && busy)) begin
        if (send_wait > 0) begin
          send_wait--;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          in_req_type    <= cur_req.req_type;
          in_object_slot <= cur_req.slot;
          in_corner      <= cur_req.corner;
          in_vert_x      <= cur_req.vx;
          in_vert_y      <= cur_req.vy;
          in_cell_x      <= cur_req.cx;
          in_cell_y      <= cur_req.cy;
          start          <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result strobe is compared with the oldest outstanding answer.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (inside_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("result %0d with no query outstanding: inside_res=%b",
                   results_seen, out_inside_res);
      end else begin
        inside_want = inside_expected.pop_front();
        if (out_inside_res !== inside_want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("result %0d inside_res mismatch: expected %b, got %b",
                     results_seen, inside_want, out_inside_res);
        end
      end
    end
  end

  // Watchdog: ends the run if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic queue_req(quad_req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
    reqs_queued++;
  endtask

  // Vertex write; the cell fields are unused and carry random values.
  task automatic queue_vertex(int slot, int corner, int x, int y);
    quad_req_t r;
    r.req_type = REQ_WRITE;
    r.slot     = slot[SLOT_IN_W-1:0];
    r.corner   = corner[CORNER_W-1:0];
    r.vx       = x[IN_COORD_W-1:0];
    r.vy       = y[IN_COORD_W-1:0];
    r.cx       = CELL_W'($urandom_range(0, CELL_MAX));
    r.cy       = CELL_W'($urandom_range(0, CELL_MAX));
    plan_x[slot * CORNERS + corner] = x;
    plan_y[slot * CORNERS + corner] = y;
    queue_req(r);
  endtask

  // Point query; the vertex fields are unused and carry random values.
  task automatic queue_query(int x, int y);
    quad_req_t r;
    r.req_type = REQ_QUERY;
    r.slot     = SLOT_IN_W'($urandom_range(0, MAX_OBJECTS - 1));
    r.corner   = CORNER_W'($urandom_range(0, LAST_CORNER));
    r.vx       = IN_COORD_W'($urandom_range(0, 65535));
    r.vy       = IN_COORD_W'($urandom_range(0, 65535));
    r.cx       = x[CELL_W-1:0];
    r.cy       = y[CELL_W-1:0];
    queue_req(r);
  endtask

  // Loads a whole quad around a random center: mostly small, some large, and now and
  // then with corners placed at random so that edges may cross.
  task automatic queue_random_quad(int slot);
    int cx, cy, r, sel, dx, dy;
    bit scramble;
    cx = $urandom_range(0, CELL_MAX);
    cy = $urandom_range(0, CELL_MAX);
    sel = $urandom_range(0, 99);
    r = (sel < 70) ? $urandom_range(1, 60) :
        ((sel < 90) ? $urandom_range(60, 4000) : $urandom_range(4000, 40000));
    scramble = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < CORNERS; k++) begin
      if (scramble) begin
        dx = int'($urandom_range(0, 2 * r)) - r;
        dy = int'($urandom_range(0, 2 * r)) - r;
      end else begin
        dx = $urandom_range(0, r);
        dy = $urandom_range(0, r);
        if (k == 0 || k == LAST_CORNER) dx = -dx;
        if (k < 2) dy = -dy;
      end
      queue_vertex(slot, k, clip(cx + dx, VERT_MIN, VERT_MAX), clip(cy + dy, VERT_MIN, VERT_MAX));
    end
  endtask

  // Waits until every item has been taken and every answer has come back.
  task automatic drain();
    while (reqs_done != reqs_queued || inside_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Object count write on the configuration channel, only with the block idle.
  task automatic set_count(int unsigned v);
    drain();
    cfg_valid        <= 1'b1;
    cfg_object_count <= v[COUNT_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    count_cfg = v;
  endtask

  initial begin
    int unsigned phase_counts [PHASES];
    int          n, base, c, pick, x, y, lo_x, hi_x, lo_y, hi_y;
    phase_counts = '{16, 31, 0, 17, 1, 5, 8};
    phase_counts[PHASES - 1] = $urandom_range(0, 31);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With the count at zero from reset every query answers 0.
    queue_query(0, 0);
    queue_query(CELL_MAX, CELL_MAX);
    queue_query(0, CELL_MAX);

    // Slot 0 is a small axis-aligned square, slot 1 spans the whole vertex range,
    // and the remaining slots get random quads so that no slot is left unwritten.
    queue_vertex(0, 0, 10, 10);
    queue_vertex(0, 1, 20, 10);
    queue_vertex(0, 2, 20, 20);
    queue_vertex(0, 3, 10, 20);
    queue_vertex(1, 0, VERT_MIN, VERT_MIN);
    queue_vertex(1, 1, VERT_MAX, VERT_MIN);
    queue_vertex(1, 2, VERT_MAX, VERT_MAX);
    queue_vertex(1, 3, VERT_MIN, VERT_MAX);
    for (int s = 2; s < MAX_OBJECTS; s++) queue_random_quad(s);

    // Square only: interior, corners, edges and just outside.
    set_count(1);
    queue_query(15, 15);
    queue_query(10, 10);
    queue_query(20, 20);
    queue_query(10, 15);
    queue_query(20, 15);
    queue_query(15, 20);
    queue_query(15, 10);
    queue_query(9, 15);
    queue_query(21, 15);

    // The full-range quad against the corners of the cell space.
    set_count(2);
    queue_query(0, 0);
    queue_query(CELL_MAX, CELL_MAX);
    queue_query(CELL_MAX, 0);
    queue_query(0, CELL_MAX);

    // Random phases: queries aimed at loaded quads, single-vertex rewrites and
    // whole-quad reloads, with the count swept across its range.
    for (int p = 0; p < PHASES; p++) begin
      set_count(phase_counts[p]);
      calm = (p % 3 == 1);
      n = (count_cfg > MAX_OBJECTS) ? MAX_OBJECTS : count_cfg;
      for (int it = 0; it < PHASE_ITEMS; it++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          x = $urandom_range(0, CELL_MAX);
          y = $urandom_range(0, CELL_MAX);
          if (n > 0 && pick < 54) begin
            base = $urandom_range(0, n - 1) * CORNERS;
            c = base + $urandom_range(0, LAST_CORNER);
            lo_x = plan_x[base];
            hi_x = lo_x;
            lo_y = plan_y[base];
            hi_y = lo_y;
            for (int k = 1; k < CORNERS; k++) begin
              if (plan_x[base + k] < lo_x) lo_x = plan_x[base + k];
              if (plan_x[base + k] > hi_x) hi_x = plan_x[base + k];
              if (plan_y[base + k] < lo_y) lo_y = plan_y[base + k];
              if (plan_y[base + k] > hi_y) hi_y = plan_y[base + k];
            end
            if (pick < 9) begin
              // Exactly on a vertex.
              x = plan_x[c];
              y = plan_y[c];
            end else begin
              x = $urandom_range(clip(hi_x + 2, 0, CELL_MAX), clip(lo_x - 2, 0, CELL_MAX));
              y = (pick < 21) ? plan_y[c] :
                  $urandom_range(clip(hi_y + 2, 0, CELL_MAX), clip(lo_y - 2, 0, CELL_MAX));
            end
          end
          queue_query(clip(x, 0, CELL_MAX), clip(y, 0, CELL_MAX));
        end else if (pick < 88) begin
          // Move one corner a little, or now and then anywhere in the vertex range.
          base = $urandom_range(0, MAX_OBJECTS - 1);
          c = $urandom_range(0, LAST_CORNER);
          if ($urandom_range(0, 4) == 0) begin
            x = int'($urandom_range(0, 65535)) + VERT_MIN;
            y = int'($urandom_range(0, 65535)) + VERT_MIN;
          end else begin
            x = clip(plan_x[base * CORNERS + c] + int'($urandom_range(0, 100)) - 50,
                     VERT_MIN, VERT_MAX);
            y = clip(plan_y[base * CORNERS + c] + int'($urandom_range(0, 100)) - 50,
                     VERT_MIN, VERT_MAX);
          end
          queue_vertex(base, c, x, y);
        end else begin
          queue_random_quad($urandom_range(0, MAX_OBJECTS - 1));
        end
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/pqst_pkg.sv
hdl/point_in_quad_set_test.sv
tb/tb.sv
